>>> hdl/wlr_pkg.sv
// ----------------------------------------------------------------------------
// Wrapped line rasterizer package
// Shared widths, configuration register codes and the segment command that
// travels from the front end to the pixel stepper.
// ----------------------------------------------------------------------------
package wlr_pkg;

  // Coordinate and screen geometry
  localparam int unsigned CoordBits   = 13;
  localparam int unsigned DiffBits    = CoordBits + 1;
  localparam int unsigned SizeBits    = 13;
  localparam int unsigned MaxSize     = 4096;
  localparam int unsigned PixBits     = $clog2(MaxSize);
  localparam int unsigned StrideBits  = 16;
  localparam int unsigned BppBits     = 3;
  localparam int unsigned AddrBits    = 32;
  localparam int unsigned ColorBits   = 32;
  localparam int unsigned RowProdBits = PixBits + StrideBits;
  localparam int unsigned ColProdBits = PixBits + BppBits;

  // Span limit and the decision term that follows from it
  localparam int unsigned MaxSpan  = 63;
  localparam int unsigned SpanBits = $clog2(MaxSpan + 1);
  localparam int unsigned DecBits  = SpanBits + 3;

  // Command queue between front end and stepper
  localparam int unsigned QueueDepth = 2;

  // Configuration port
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [CfgIdxBits-1:0] CFG_SCREEN_WIDTH  = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CFG_SCREEN_HEIGHT = CfgIdxBits'(1);
  localparam logic [CfgIdxBits-1:0] CFG_ROW_STRIDE    = CfgIdxBits'(2);
  localparam logic [CfgIdxBits-1:0] CFG_BYTES_PER_PIX = CfgIdxBits'(3);
  localparam logic [CfgIdxBits-1:0] CFG_FRAME_BASE    = CfgIdxBits'(4);

  localparam logic [SizeBits-1:0]   RST_SCREEN_WIDTH  = SizeBits'(1024);
  localparam logic [SizeBits-1:0]   RST_SCREEN_HEIGHT = SizeBits'(768);
  localparam logic [StrideBits-1:0] RST_ROW_STRIDE    = StrideBits'(4096);
  localparam logic [BppBits-1:0]    RST_BYTES_PER_PIX = BppBits'(4);
  localparam logic [AddrBits-1:0]   RST_FRAME_BASE    = '0;

  // One classified segment, ready to be stepped
  typedef struct packed {
    logic                 err;
    logic                 x_major;
    logic                 minor_neg;
    logic [SpanBits-1:0]  span;
    logic [SpanBits-1:0]  dmin;
    logic [PixBits-1:0]   start_x;
    logic [PixBits-1:0]   start_y;
    logic [ColorBits-1:0] color;
  } wlr_cmd_t;

endpackage

>>> hdl/wlr_wrap.sv
// ----------------------------------------------------------------------------
// Wrapped line rasterizer: coordinate wrap unit
// Reduces a signed coordinate into 0..size-1 with a restoring remainder,
// one quotient bit per cycle, then folds negative values back into range.
// ----------------------------------------------------------------------------
module wlr_wrap (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [wlr_pkg::CoordBits-1:0] coord_i,
  input  logic [wlr_pkg::SizeBits-1:0]        size_i,
  output logic                                done_o,
  output logic [wlr_pkg::PixBits-1:0]         res_o
);
  import wlr_pkg::*;

  localparam int unsigned CntBits = $clog2(CoordBits + 1);

  localparam logic [1:0] W_IDLE = 2'd0;
  localparam logic [1:0] W_DIV  = 2'd1;
  localparam logic [1:0] W_FIX  = 2'd2;

  logic [1:0]           st_q, st_d;
  logic [CntBits-1:0]   cnt_q;
  logic                 done_q;
  logic                 neg_q;
  logic [CoordBits-1:0] mag_q;
  logic [SizeBits-1:0]  rem_q;
  logic [PixBits-1:0]   res_q;

  logic [SizeBits:0]    trial;
  logic                 fits;
  logic [SizeBits-1:0]  rem_next;
  logic [SizeBits-1:0]  folded;

  // Shift in the next magnitude bit and subtract the size where it fits
  assign trial    = {rem_q, mag_q[CoordBits-1]};
  assign fits     = trial >= {1'b0, size_i};
  assign rem_next = fits ? SizeBits'(trial - {1'b0, size_i}) : trial[SizeBits-1:0];
  assign folded   = (neg_q && (rem_q != '0)) ? (size_i - rem_q) : rem_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      W_IDLE: begin
        if (start_i) st_d = W_DIV;
      end
      W_DIV: begin
        if (cnt_q == CntBits'(1)) st_d = W_FIX;
      end
      W_FIX: begin
        st_d = W_IDLE;
      end
      default: st_d = W_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= W_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (start_i) begin
        cnt_q  <= CntBits'(CoordBits);
        done_q <= 1'b0;
      end else if (st_q == W_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end else if (st_q == W_FIX) begin
        done_q <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= coord_i[CoordBits-1];
      mag_q <= coord_i[CoordBits-1] ? CoordBits'(-coord_i) : CoordBits'(coord_i);
      rem_q <= '0;
    end else if (st_q == W_DIV) begin
      rem_q <= rem_next;
      mag_q <= {mag_q[CoordBits-2:0], 1'b0};
    end else if (st_q == W_FIX) begin
      res_q <= folded[PixBits-1:0];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // A finished reduction lies inside the screen
  a_res_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == W_FIX) |=> (done_q && ({1'b0, res_q} < size_i)))
    else $error("wrap result outside screen size");

endmodule

>>> hdl/wlr_front.sv
// ----------------------------------------------------------------------------
// Wrapped line rasterizer: front end
// Accepts a segment, picks the major axis and direction, checks the span and,
// if in range, wraps the start point into the screen and queues the command.
// ----------------------------------------------------------------------------
module wlr_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [wlr_pkg::CoordBits-1:0] start_x_i,
  input  logic signed [wlr_pkg::CoordBits-1:0] start_y_i,
  input  logic signed [wlr_pkg::CoordBits-1:0] end_x_i,
  input  logic signed [wlr_pkg::CoordBits-1:0] end_y_i,
  input  logic [wlr_pkg::ColorBits-1:0]        pixel_color_i,
  input  logic [wlr_pkg::SizeBits-1:0]         width_i,
  input  logic [wlr_pkg::SizeBits-1:0]         height_i,
  output logic                                 push_o,
  input  logic                                 push_ready_i,
  output wlr_pkg::wlr_cmd_t                    cmd_o
);
  import wlr_pkg::*;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_DIFF  = 3'd1;
  localparam logic [2:0] F_CLASS = 3'd2;
  localparam logic [2:0] F_WRAP  = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  logic [2:0] st_q, st_d;

  logic signed [CoordBits-1:0] x0_q, y0_q, x1_q, y1_q;
  logic [ColorBits-1:0]        color_q;
  logic signed [DiffBits-1:0]  dx_q, dy_q;
  logic [CoordBits-1:0]        adx_q, ady_q;
  wlr_cmd_t                    cmd_q;

  logic signed [DiffBits-1:0]  dx, dy, dmaj, dmn;
  logic                        x_major, swap, neg, err;
  logic [CoordBits-1:0]        span, dmin_abs;
  logic signed [CoordBits-1:0] sx, sy;
  logic                        wrap_start;
  logic                        wx_done, wy_done;
  logic [PixBits-1:0]          wx_res, wy_res;

  // Endpoint differences
  assign dx = DiffBits'(x1_q) - DiffBits'(x0_q);
  assign dy = DiffBits'(y1_q) - DiffBits'(y0_q);

  // Classify: major axis, direction, span and start point
  assign x_major  = ady_q < adx_q;
  assign dmaj     = x_major ? dx_q : dy_q;
  assign dmn      = x_major ? dy_q : dx_q;
  assign swap     = dmaj[DiffBits-1];
  assign span     = x_major ? adx_q : ady_q;
  assign dmin_abs = x_major ? ady_q : adx_q;
  assign neg      = swap ? (!dmn[DiffBits-1] && (dmn != '0)) : dmn[DiffBits-1];
  assign err      = span > CoordBits'(MaxSpan);
  assign sx       = swap ? x1_q : x0_q;
  assign sy       = swap ? y1_q : y0_q;

  assign wrap_start = (st_q == F_CLASS) && !err;

  wlr_wrap u_wrap_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wrap_start),
    .coord_i (sx),
    .size_i  (width_i),
    .done_o  (wx_done),
    .res_o   (wx_res)
  );

  wlr_wrap u_wrap_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wrap_start),
    .coord_i (sy),
    .size_i  (height_i),
    .done_o  (wy_done),
    .res_o   (wy_res)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      F_IDLE: begin
        if (in_valid_i) st_d = F_DIFF;
      end
      F_DIFF: begin
        st_d = F_CLASS;
      end
      F_CLASS: begin
        st_d = err ? F_PUSH : F_WRAP;
      end
      F_WRAP: begin
        if (wx_done && wy_done) st_d = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready_i) st_d = F_IDLE;
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Capture the segment and build the command step by step
  always_ff @(posedge clk_i) begin
    case (st_q)
      F_IDLE: begin
        x0_q    <= start_x_i;
        y0_q    <= start_y_i;
        x1_q    <= end_x_i;
        y1_q    <= end_y_i;
        color_q <= pixel_color_i;
      end
      F_DIFF: begin
        dx_q  <= dx;
        dy_q  <= dy;
        adx_q <= dx[DiffBits-1] ? CoordBits'(-dx) : CoordBits'(dx);
        ady_q <= dy[DiffBits-1] ? CoordBits'(-dy) : CoordBits'(dy);
      end
      F_CLASS: begin
        cmd_q.err       <= err;
        cmd_q.x_major   <= x_major;
        cmd_q.minor_neg <= neg;
        cmd_q.span      <= err ? '0 : span[SpanBits-1:0];
        cmd_q.dmin      <= err ? '0 : dmin_abs[SpanBits-1:0];
        cmd_q.start_x   <= '0;
        cmd_q.start_y   <= '0;
        cmd_q.color     <= color_q;
      end
      F_WRAP: begin
        cmd_q.start_x <= wx_res;
        cmd_q.start_y <= wy_res;
      end
      default: begin
        cmd_q <= cmd_q;
      end
    endcase
  end

  assign in_ready_o = (st_q == F_IDLE);
  assign push_o     = (st_q == F_PUSH);
  assign cmd_o      = cmd_q;

endmodule

>>> hdl/wlr_fifo.sv
// ----------------------------------------------------------------------------
// Wrapped line rasterizer: command queue
// Short register queue that decouples the front end from the stepper.
// ----------------------------------------------------------------------------
module wlr_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              push_ready_o,
  input  wlr_pkg::wlr_cmd_t cmd_i,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output wlr_pkg::wlr_cmd_t cmd_o
);
  import wlr_pkg::*;

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  wlr_cmd_t            mem_q [QueueDepth];
  logic [PtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]  count_q;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != CntBits'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign cmd_o        = mem_q[rd_ptr_q];

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store the incoming command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(QueueDepth))
    else $error("command queue overfilled");

endmodule

>>> hdl/wlr_back.sv
// ----------------------------------------------------------------------------
// Wrapped line rasterizer: pixel stepper
// Steps a queued segment one pixel per cycle, unless the output stalls, with
// wrapped coordinates; a short output pipeline forms the framebuffer address.
// ----------------------------------------------------------------------------
module wlr_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  wlr_pkg::wlr_cmd_t               cmd_i,
  input  logic [wlr_pkg::SizeBits-1:0]    width_i,
  input  logic [wlr_pkg::SizeBits-1:0]    height_i,
  input  logic [wlr_pkg::StrideBits-1:0]  stride_i,
  input  logic [wlr_pkg::BppBits-1:0]     bpp_i,
  input  logic [wlr_pkg::AddrBits-1:0]    base_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [wlr_pkg::PixBits-1:0]     pixel_x_o,
  output logic [wlr_pkg::PixBits-1:0]     pixel_y_o,
  output logic [wlr_pkg::AddrBits-1:0]    pixel_address_o,
  output logic [wlr_pkg::ColorBits-1:0]   color_out_o,
  output logic                            last_pixel_o,
  output logic                            span_error_o
);
  import wlr_pkg::*;

  // Stepper state
  logic                       busy_q;
  logic                       err_q, xmaj_q, neg_q;
  logic [SpanBits-1:0]        cnt_q, dmin_q, span_q;
  logic signed [DecBits-1:0]  dec_q;
  logic [PixBits-1:0]         cx_q, cy_q;
  logic [ColorBits-1:0]       col_q;

  // Pipeline stages
  logic                       s1_v_q, s2_v_q, out_valid_q;
  logic [PixBits-1:0]         s1_x_q, s1_y_q, s2_x_q, s2_y_q;
  logic                       s1_last_q, s1_err_q, s2_last_q, s2_err_q;
  logic [ColorBits-1:0]       s1_col_q, s2_col_q;
  logic [RowProdBits-1:0]     s2_row_q;
  logic [ColProdBits-1:0]     s2_colp_q;
  logic [PixBits-1:0]         out_x_q, out_y_q;
  logic [AddrBits-1:0]        out_addr_q;
  logic [ColorBits-1:0]       out_col_q;
  logic                       out_last_q, out_err_q;

  logic                       adv, emit, load, minor_step;
  logic [SizeBits-1:0]        wm_full, hm_full;
  logic [PixBits-1:0]         wmax, hmax;
  logic [PixBits-1:0]         cx_d, cy_d;
  logic signed [DecBits-1:0]  dec_d, dec_init;

  function automatic logic [PixBits-1:0] wrap_inc(input logic [PixBits-1:0] v,
                                                  input logic [PixBits-1:0] vmax);
    return (v == vmax) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [PixBits-1:0] wrap_dec(input logic [PixBits-1:0] v,
                                                  input logic [PixBits-1:0] vmax);
    return (v == '0) ? vmax : v - 1'b1;
  endfunction

  assign wm_full = width_i - 1'b1;
  assign hm_full = height_i - 1'b1;
  assign wmax    = wm_full[PixBits-1:0];
  assign hmax    = hm_full[PixBits-1:0];

  // Advance the whole pipeline whenever the output register is free
  assign adv       = !out_valid_q || out_ready_i;
  assign emit      = busy_q && adv;
  assign load      = q_valid_i && !busy_q;
  assign q_ready_o = !busy_q;

  // Bresenham decision: step the minor axis while the term is positive
  assign minor_step = !dec_q[DecBits-1] && (dec_q != '0);
  assign dec_init   = DecBits'({cmd_i.dmin, 1'b0}) - DecBits'(cmd_i.span);
  assign dec_d      = minor_step
                    ? dec_q + DecBits'({dmin_q, 1'b0}) - DecBits'({span_q, 1'b0})
                    : dec_q + DecBits'({dmin_q, 1'b0});

  // Next wrapped position: major axis always rises
  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    if (xmaj_q) begin
      cx_d = wrap_inc(cx_q, wmax);
      if (minor_step) cy_d = neg_q ? wrap_dec(cy_q, hmax) : wrap_inc(cy_q, hmax);
    end else begin
      cy_d = wrap_inc(cy_q, hmax);
      if (minor_step) cx_d = neg_q ? wrap_dec(cx_q, wmax) : wrap_inc(cx_q, wmax);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (emit && (cnt_q == '0)) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        s1_v_q      <= emit;
        s2_v_q      <= s1_v_q;
        out_valid_q <= s2_v_q;
      end
    end
  end

  // Load a segment, then walk it
  always_ff @(posedge clk_i) begin
    if (load) begin
      err_q  <= cmd_i.err;
      xmaj_q <= cmd_i.x_major;
      neg_q  <= cmd_i.minor_neg;
      cnt_q  <= cmd_i.span;
      span_q <= cmd_i.span;
      dmin_q <= cmd_i.dmin;
      dec_q  <= dec_init;
      cx_q   <= cmd_i.start_x;
      cy_q   <= cmd_i.start_y;
      col_q  <= cmd_i.color;
    end else if (emit) begin
      cnt_q <= cnt_q - 1'b1;
      dec_q <= dec_d;
      cx_q  <= cx_d;
      cy_q  <= cy_d;
    end
  end

  // Pixel, products, then address sum
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q    <= cx_q;
      s1_y_q    <= cy_q;
      s1_last_q <= (cnt_q == '0);
      s1_err_q  <= err_q;
      s1_col_q  <= col_q;

      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_last_q <= s1_last_q;
      s2_err_q  <= s1_err_q;
      s2_col_q  <= s1_col_q;
      s2_row_q  <= RowProdBits'(s1_y_q * stride_i);
      s2_colp_q <= ColProdBits'(s1_x_q * bpp_i);

      out_last_q <= s2_last_q;
      out_err_q  <= s2_err_q;
      if (s2_err_q) begin
        out_x_q    <= '0;
        out_y_q    <= '0;
        out_addr_q <= '0;
        out_col_q  <= '0;
      end else begin
        out_x_q    <= s2_x_q;
        out_y_q    <= s2_y_q;
        out_addr_q <= base_i + AddrBits'(s2_row_q) + AddrBits'(s2_colp_q);
        out_col_q  <= s2_col_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = out_x_q;
  assign pixel_y_o       = out_y_q;
  assign pixel_address_o = out_addr_q;
  assign color_out_o     = out_col_q;
  assign last_pixel_o    = out_last_q;
  assign span_error_o    = out_err_q;

  // An error result is a single, blank, final result
  a_err_blank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && span_error_o) |->
      (last_pixel_o && (pixel_address_o == '0) && (color_out_o == '0)))
    else $error("span error result not blank");

  // The walker stays inside the screen
  a_pos_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ((cx_q <= wmax) && (cy_q <= hmax)))
    else $error("walker position outside screen");

  // An error segment yields exactly one pixel slot
  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_err_q) |-> s1_last_q)
    else $error("error segment not closed on its first result");

endmodule

>>> hdl/wrapped_line_rasterizer_top.sv
// Path: a segment passes the front end difference and classify states, the serial
//   wrap of the start point, the queue push, the stepper load and 3 pipe stages
//   before its first pixel is valid; a span error result skips the wrap.
// Rate: one pixel per cycle while the output is not stalled; the front end takes a
//   new segment only after pushing the last one, and the queue lets it prepare the
//   next segment while the stepper walks the current one.
// Reset: asynchronous, active low; clears control state and restores register defaults.
// ----------------------------------------------------------------------------
// Wrapped line rasterizer, top level
// Configuration registers, front end, command queue and pixel stepper.
// ----------------------------------------------------------------------------
module wrapped_line_rasterizer_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wlr_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [wlr_pkg::CfgDataBits-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [wlr_pkg::CoordBits-1:0] start_x_i,
  input  logic signed [wlr_pkg::CoordBits-1:0] start_y_i,
  input  logic signed [wlr_pkg::CoordBits-1:0] end_x_i,
  input  logic signed [wlr_pkg::CoordBits-1:0] end_y_i,
  input  logic [wlr_pkg::ColorBits-1:0]        pixel_color_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [wlr_pkg::PixBits-1:0]          pixel_x_o,
  output logic [wlr_pkg::PixBits-1:0]          pixel_y_o,
  output logic [wlr_pkg::AddrBits-1:0]         pixel_address_o,
  output logic [wlr_pkg::ColorBits-1:0]        color_out_o,
  output logic                                 last_pixel_o,
  output logic                                 span_error_o
);
  import wlr_pkg::*;

  logic [SizeBits-1:0]   width_q, height_q;
  logic [StrideBits-1:0] stride_q;
  logic [BppBits-1:0]    bpp_q;
  logic [AddrBits-1:0]   base_q;
  logic [SizeBits-1:0]   eff_w, eff_h;

  logic     push, push_ready, q_valid, q_ready;
  wlr_cmd_t front_cmd, queue_cmd;

  // Clamp a screen size into 1..MaxSize
  function automatic logic [SizeBits-1:0] eff_size(input logic [SizeBits-1:0] s);
    logic [SizeBits-1:0] r;
    if (s == '0) begin
      r = SizeBits'(1);
    end else if (s > SizeBits'(MaxSize)) begin
      r = SizeBits'(MaxSize);
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_SCREEN_WIDTH;
      height_q <= RST_SCREEN_HEIGHT;
      stride_q <= RST_ROW_STRIDE;
      bpp_q    <= RST_BYTES_PER_PIX;
      base_q   <= RST_FRAME_BASE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i[SizeBits-1:0];
        CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i[SizeBits-1:0];
        CFG_ROW_STRIDE:    stride_q <= cfg_wdata_i[StrideBits-1:0];
        CFG_BYTES_PER_PIX: bpp_q    <= cfg_wdata_i[BppBits-1:0];
        CFG_FRAME_BASE:    base_q   <= cfg_wdata_i[AddrBits-1:0];
        default: ;
      endcase
    end
  end

  assign eff_w = eff_size(width_q);
  assign eff_h = eff_size(height_q);

  wlr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .pixel_color_i (pixel_color_i),
    .width_i       (eff_w),
    .height_i      (eff_h),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .cmd_o         (front_cmd)
  );

  wlr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .cmd_i        (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_ready),
    .cmd_o        (queue_cmd)
  );

  wlr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_ready_o       (q_ready),
    .cmd_i           (queue_cmd),
    .width_i         (eff_w),
    .height_i        (eff_h),
    .stride_i        (stride_q),
    .bpp_i           (bpp_q),
    .base_i          (base_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_address_o (pixel_address_o),
    .color_out_o     (color_out_o),
    .last_pixel_o    (last_pixel_o),
    .span_error_o    (span_error_o)
  );

endmodule
